/* hdl/polynomial_derivative_evaluator_macros.svh */
// Assertion helpers used by pde_checker, the checker of the derivative evaluator.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef POLYNOMIAL_DERIVATIVE_EVALUATOR_MACROS_SVH
`define POLYNOMIAL_DERIVATIVE_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pde_pkg.sv */
package pde_pkg;

    localparam int NUM_COEF_REGS  = 6;
    localparam int MAX_COEFFS_DEF = 6;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 3;
    localparam int ORD_W  = 3;
    localparam int IDX_W  = 3;
    localparam int SH_W   = 4;
    localparam int FACT_W = 7;
    // Coefficient magnitude times the largest factorial ratio (120) stays below 2^38.
    localparam int MC_W   = 38;
    localparam int WIDE_W = 64;
    localparam int TP_W   = MC_W + 32;
    localparam int PROD_W = MC_W + WIDE_W;

    localparam logic [IDX_W-1:0] REG_COEF_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_A     = 3'd1;

    localparam logic [WIDE_W-1:0] ONE_Q16  = 64'd65536;
    localparam logic [WIDE_W-1:0] SAT_POS  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [WIDE_W-1:0] SAT_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] Q_MAX32  = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] Q_MIN32  = 32'h8000_0000;

    // j!/(j-k)! indexed by order j, then derivative order k.
    localparam logic [FACT_W-1:0] FACT_TBL [0:NUM_COEF_REGS-1][0:NUM_COEF_REGS-1] = '{
        '{7'd1, 7'd0, 7'd0,  7'd0,  7'd0,   7'd0  },
        '{7'd1, 7'd1, 7'd0,  7'd0,  7'd0,   7'd0  },
        '{7'd1, 7'd2, 7'd2,  7'd0,  7'd0,   7'd0  },
        '{7'd1, 7'd3, 7'd6,  7'd6,  7'd0,   7'd0  },
        '{7'd1, 7'd4, 7'd12, 7'd24, 7'd24,  7'd0  },
        '{7'd1, 7'd5, 7'd20, 7'd60, 7'd120, 7'd120}
    };

    // Running state of one evaluation between the term steps.
    // pt_*: point t, pw_*: current power of t, both in sign and magnitude form.
    typedef struct packed {
        logic [DATA_W-1:0] pt_mag;
        logic              pt_neg;
        logic [WIDE_W-1:0] pw_mag;
        logic              pw_neg;
        logic [WIDE_W-1:0] acc;
        logic [WIDE_W-1:0] term;
    } pde_item_t;

    function automatic logic [WIDE_W-1:0] sat_add64(input logic [WIDE_W-1:0] a,
                                                    input logic [WIDE_W-1:0] b);
        logic [WIDE_W:0]   s;
        logic [WIDE_W-1:0] res;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1])
        begin
            res = s[WIDE_W] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            res = s[WIDE_W-1:0];
        end
        return res;
    endfunction

    // Magnitude of floor(+/-prod / 2^16), saturated to the signed 64-bit range.
    function automatic logic [WIDE_W-1:0] q16_mag(input logic [PROD_W-1:0] prod,
                                                  input logic              neg);
        logic [PROD_W-17:0] q;
        logic               inc;
        logic [WIDE_W-1:0]  res;
        q   = prod[PROD_W-1:16];
        inc = neg & (|prod[15:0]);
        if (|q[PROD_W-17:WIDE_W-1])
        begin
            res = neg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            res = q[WIDE_W-1:0] + WIDE_W'(inc);
        end
        return res;
    endfunction

    // Two's complement of floor(+/-prod / 2^16), saturated. For a negative
    // product -(q + inc) equals ~q + !inc, so one increment does both.
    function automatic logic [WIDE_W-1:0] q16_signed(input logic [PROD_W-1:0] prod,
                                                     input logic              neg);
        logic [PROD_W-17:0] q;
        logic               inc;
        logic [WIDE_W-1:0]  res;
        q   = prod[PROD_W-1:16];
        inc = neg & (|prod[15:0]);
        if (|q[PROD_W-17:WIDE_W-1])
        begin
            res = neg ? SAT_NEG : SAT_POS;
        end
        else if (neg)
        begin
            res = ~q[WIDE_W-1:0] + {{(WIDE_W-1){1'b0}}, !inc};
        end
        else
        begin
            res = q[WIDE_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hdl/pde_front.sv */
module pde_front #(
    parameter int LANES = pde_pkg::NUM_COEF_REGS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [pde_pkg::CNT_W-1:0]                     coef_count,
    input  logic [pde_pkg::NUM_COEF_REGS*pde_pkg::DATA_W-1:0] coef_vec,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [pde_pkg::DATA_W-1:0]                    in_point,
    input  logic [pde_pkg::ORD_W-1:0]                     in_order,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output pde_pkg::pde_item_t                            out_item,
    output logic [LANES-1:0][pde_pkg::MC_W-1:0]           out_cmag,
    output logic [LANES-1:0]                              out_cneg
);
    import pde_pkg::*;

    logic                            f1_valid_reg;
    logic [DATA_W-1:0]               f1_point_reg;
    logic [LANES-1:0][DATA_W-1:0]    f1_coef_reg;
    logic [LANES-1:0][FACT_W-1:0]    f1_fact_reg;
    logic [LANES-1:0][DATA_W-1:0]    f1_coef_next;
    logic [LANES-1:0][FACT_W-1:0]    f1_fact_next;

    logic                            f2_valid_reg;
    pde_item_t                       f2_item_reg;
    logic [LANES-1:0][MC_W-1:0]      f2_cmag_reg;
    logic [LANES-1:0]                f2_cneg_reg;
    pde_item_t                       f2_item_next;
    logic [LANES-1:0][MC_W-1:0]      f2_cmag_next;
    logic [LANES-1:0]                f2_cneg_next;

    logic                            f1_rdy;
    logic                            f2_rdy;

    logic [CNT_W-1:0]                n_eff;
    logic [SH_W-1:0]                 shift_slots;
    logic [NUM_COEF_REGS*DATA_W-1:0] aligned;
    logic [LANES-1:0][SH_W-1:0]      lane_order;
    logic [LANES-1:0]                lane_active;
    logic [LANES-1:0][DATA_W-1:0]    lane_cmag;
    logic [LANES-1:0][MC_W-1:0]      lane_prod;

    assign f2_rdy   = !f2_valid_reg || out_ready;
    assign f1_rdy   = !f1_valid_reg || f2_rdy;
    assign in_ready = f1_rdy;

    // Slot s of coef_vec holds the coefficient of order s + count - 6, so a right
    // shift by (6 - count + k) slots puts the order k + i coefficient in lane i.
    // Orders at or above the count shift in as zero.
    always_comb
    begin
        n_eff       = (coef_count > CNT_W'(LANES)) ? CNT_W'(LANES) : coef_count;
        shift_slots = SH_W'(NUM_COEF_REGS) - {1'b0, n_eff} + {1'b0, in_order};
        aligned     = coef_vec >> {shift_slots, 5'd0};
        for (int i = 0; i < LANES; i++)
        begin
            lane_order[i]   = {1'b0, in_order} + SH_W'(i);
            lane_active[i]  = lane_order[i] < {1'b0, n_eff};
            f1_coef_next[i] = aligned[i*DATA_W +: DATA_W];
            f1_fact_next[i] = lane_active[i]
                              ? FACT_TBL[lane_order[i][2:0]][in_order]
                              : '0;
        end
    end

    always_comb
    begin
        f2_item_next.pt_neg = f1_point_reg[DATA_W-1];
        f2_item_next.pt_mag = f1_point_reg[DATA_W-1] ? (~f1_point_reg + 32'd1) : f1_point_reg;
        f2_item_next.pw_mag = ONE_Q16;
        f2_item_next.pw_neg = 1'b0;
        f2_item_next.acc    = '0;
        f2_item_next.term   = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_cmag[i]    = f1_coef_reg[i][DATA_W-1] ? (~f1_coef_reg[i] + 32'd1)
                                                        : f1_coef_reg[i];
            lane_prod[i]    = MC_W'(lane_cmag[i]) * MC_W'(f1_fact_reg[i]);
            f2_cmag_next[i] = lane_prod[i];
            f2_cneg_next[i] = f1_coef_reg[i][DATA_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_rdy)
            begin
                f1_valid_reg <= in_valid;
            end
            if (f2_rdy)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_rdy && in_valid)
        begin
            f1_point_reg <= in_point;
            f1_coef_reg  <= f1_coef_next;
            f1_fact_reg  <= f1_fact_next;
        end
        if (f2_rdy && f1_valid_reg)
        begin
            f2_item_reg <= f2_item_next;
            f2_cmag_reg <= f2_cmag_next;
            f2_cneg_reg <= f2_cneg_next;
        end
    end

    assign out_valid = f2_valid_reg;
    assign out_item  = f2_item_reg;
    assign out_cmag  = f2_cmag_reg;
    assign out_cneg  = f2_cneg_reg;

endmodule

/* hdl/pde_step.sv */
module pde_step #(
    parameter int LANES = pde_pkg::NUM_COEF_REGS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pde_pkg::pde_item_t                  in_item,
    input  logic [LANES-1:0][pde_pkg::MC_W-1:0] in_cmag,
    input  logic [LANES-1:0]                    in_cneg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pde_pkg::pde_item_t                  out_item,
    output logic [LANES-1:0][pde_pkg::MC_W-1:0] out_cmag,
    output logic [LANES-1:0]                    out_cneg
);
    import pde_pkg::*;

    // Stage A: partial products of power * t and coefficient * power, and the
    // previous term folded into the running sum.
    logic                        a_valid_reg;
    pde_item_t                   a_item_reg;
    logic [WIDE_W-1:0]           a_pp_lo_reg;
    logic [WIDE_W-1:0]           a_pp_hi_reg;
    logic [TP_W-1:0]             a_tp_lo_reg;
    logic [TP_W-1:0]             a_tp_hi_reg;
    logic                        a_pwneg_reg;
    logic                        a_tmneg_reg;
    logic [LANES-1:0][MC_W-1:0]  a_cmag_reg;
    logic [LANES-1:0]            a_cneg_reg;
    pde_item_t                   a_item_next;
    logic [WIDE_W-1:0]           a_pp_lo_next;
    logic [WIDE_W-1:0]           a_pp_hi_next;
    logic [TP_W-1:0]             a_tp_lo_next;
    logic [TP_W-1:0]             a_tp_hi_next;

    // Stage B: full products.
    logic                        b_valid_reg;
    pde_item_t                   b_item_reg;
    logic [PROD_W-1:0]           b_pprod_reg;
    logic [PROD_W-1:0]           b_tprod_reg;
    logic                        b_pwneg_reg;
    logic                        b_tmneg_reg;
    logic [LANES-1:0][MC_W-1:0]  b_cmag_reg;
    logic [LANES-1:0]            b_cneg_reg;
    logic [PROD_W-1:0]           b_pprod_next;
    logic [PROD_W-1:0]           b_tprod_next;

    // Stage C: rounding and saturation of both products.
    logic                        c_valid_reg;
    pde_item_t                   c_item_reg;
    logic [LANES-1:0][MC_W-1:0]  c_cmag_reg;
    logic [LANES-1:0]            c_cneg_reg;
    pde_item_t                   c_item_next;

    logic                        a_rdy;
    logic                        b_rdy;
    logic                        c_rdy;

    assign c_rdy    = !c_valid_reg || out_ready;
    assign b_rdy    = !b_valid_reg || c_rdy;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign in_ready = a_rdy;

    always_comb
    begin
        a_item_next     = in_item;
        a_item_next.acc = sat_add64(in_item.acc, in_item.term);
        a_pp_lo_next    = in_item.pw_mag[31:0] * in_item.pt_mag;
        a_pp_hi_next    = in_item.pw_mag[63:32] * in_item.pt_mag;
        a_tp_lo_next    = in_cmag[0] * in_item.pw_mag[31:0];
        a_tp_hi_next    = in_cmag[0] * in_item.pw_mag[63:32];
    end

    always_comb
    begin
        b_pprod_next = {6'b0, a_pp_hi_reg, 32'b0} + {38'b0, a_pp_lo_reg};
        b_tprod_next = {a_tp_hi_reg, 32'b0} + {32'b0, a_tp_lo_reg};
    end

    always_comb
    begin
        c_item_next        = b_item_reg;
        c_item_next.pw_mag = q16_mag(b_pprod_reg, b_pwneg_reg);
        c_item_next.pw_neg = b_pwneg_reg;
        c_item_next.term   = q16_signed(b_tprod_reg, b_tmneg_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_rdy)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_rdy)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Lane 0 is consumed here; the remaining lanes move down by one.
    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_item_reg  <= a_item_next;
            a_pp_lo_reg <= a_pp_lo_next;
            a_pp_hi_reg <= a_pp_hi_next;
            a_tp_lo_reg <= a_tp_lo_next;
            a_tp_hi_reg <= a_tp_hi_next;
            a_pwneg_reg <= in_item.pw_neg ^ in_item.pt_neg;
            a_tmneg_reg <= in_cneg[0] ^ in_item.pw_neg;
            a_cmag_reg  <= in_cmag >> MC_W;
            a_cneg_reg  <= in_cneg >> 1;
        end
        if (b_rdy && a_valid_reg)
        begin
            b_item_reg  <= a_item_reg;
            b_pprod_reg <= b_pprod_next;
            b_tprod_reg <= b_tprod_next;
            b_pwneg_reg <= a_pwneg_reg;
            b_tmneg_reg <= a_tmneg_reg;
            b_cmag_reg  <= a_cmag_reg;
            b_cneg_reg  <= a_cneg_reg;
        end
        if (c_rdy && b_valid_reg)
        begin
            c_item_reg <= c_item_next;
            c_cmag_reg <= b_cmag_reg;
            c_cneg_reg <= b_cneg_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;
    assign out_cmag  = c_cmag_reg;
    assign out_cneg  = c_cneg_reg;

endmodule

/* hdl/pde_tail.sv */
module pde_tail (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pde_pkg::pde_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pde_pkg::DATA_W-1:0]  out_value,
    output logic                        out_overflow
);
    import pde_pkg::*;

    logic              t1_valid_reg;
    logic [WIDE_W-1:0] t1_acc_reg;
    logic              t2_valid_reg;
    logic [DATA_W-1:0] t2_value_reg;
    logic              t2_ovf_reg;
    logic [DATA_W-1:0] t2_value_next;
    logic              t2_ovf_next;
    logic              in_range;
    logic              t1_rdy;
    logic              t2_rdy;

    assign t2_rdy   = !t2_valid_reg || out_ready;
    assign t1_rdy   = !t1_valid_reg || t2_rdy;
    assign in_ready = t1_rdy;

    // The sum fits in 32 bits when bits 63 down to 31 all agree.
    always_comb
    begin
        in_range      = (&t1_acc_reg[WIDE_W-1:DATA_W-1]) || !(|t1_acc_reg[WIDE_W-1:DATA_W-1]);
        t2_ovf_next   = !in_range;
        if (in_range)
        begin
            t2_value_next = t1_acc_reg[DATA_W-1:0];
        end
        else
        begin
            t2_value_next = t1_acc_reg[WIDE_W-1] ? Q_MIN32 : Q_MAX32;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            if (t1_rdy)
            begin
                t1_valid_reg <= in_valid;
            end
            if (t2_rdy)
            begin
                t2_valid_reg <= t1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_rdy && in_valid)
        begin
            t1_acc_reg <= sat_add64(in_item.acc, in_item.term);
        end
        if (t2_rdy && t1_valid_reg)
        begin
            t2_value_reg <= t2_value_next;
            t2_ovf_reg   <= t2_ovf_next;
        end
    end

    assign out_valid    = t2_valid_reg;
    assign out_value    = t2_value_reg;
    assign out_overflow = t2_ovf_reg;

endmodule

/* hdl/polynomial_derivative_evaluator.sv */
// Channel   Direction  Signals                               Content
// cfg       in         cfg_valid/cfg_ready/cfg_index/cfg_data  register writes, index 0..6
// s_axis    in         s_tvalid/s_tready/s_tdata             point, derivative order
// m_axis    out        m_tvalid/m_tready/m_tdata/m_tuser     value, overflow flag
//
// One evaluation enters per cycle while s_tready is high; each passes from input
// transfer to output through the front stages f1 and f2, the three-stage term step
// that is repeated once per coefficient lane, and the tail stages t1 and t2.
// Reset clears the coefficient registers, the count and every stage valid bit.
// A stalled output holds its result; earlier stages keep filling empty slots and
// s_tready falls only when every stage holds an item.
module polynomial_derivative_evaluator #(
    parameter int MAX_COEFFS = pde_pkg::MAX_COEFFS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pde_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pde_pkg::DATA_W-1:0]   cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // point [31:0], deriv_order [34:32]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pde_pkg::DATA_W-1:0]   m_tdata,   // value [31:0]
    output logic                         m_tuser    // overflow [0]
);
    import pde_pkg::*;

    localparam int LANES = (MAX_COEFFS < NUM_COEF_REGS) ? MAX_COEFFS : NUM_COEF_REGS;

    logic [CNT_W-1:0]                coef_count_reg;
    logic [DATA_W-1:0]               coef_regs [0:NUM_COEF_REGS-1];
    logic [NUM_COEF_REGS*DATA_W-1:0] coef_vec;

    logic                            chain_valid [0:LANES];
    logic                            chain_ready [0:LANES];
    pde_item_t                       chain_item  [0:LANES];
    logic [LANES-1:0][MC_W-1:0]      chain_cmag  [0:LANES];
    logic [LANES-1:0]                chain_cneg  [0:LANES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_count_reg <= '0;
        end
        else if (cfg_valid && cfg_index == REG_COEF_COUNT)
        begin
            coef_count_reg <= cfg_data[CNT_W-1:0];
        end
    end

    // Coefficient a (highest order in use) ends up in the top slot of coef_vec.
    for (genvar g = 0; g < NUM_COEF_REGS; g++)
    begin : g_coef
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_regs[g] <= '0;
            end
            else if (cfg_valid && cfg_index == IDX_W'(REG_COEF_A + g))
            begin
                coef_regs[g] <= cfg_data;
            end
        end
        assign coef_vec[(NUM_COEF_REGS-1-g)*DATA_W +: DATA_W] = coef_regs[g];
    end

    pde_front #(
        .LANES (LANES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_count (coef_count_reg),
        .coef_vec   (coef_vec),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_point   (s_tdata[31:0]),
        .in_order   (s_tdata[34:32]),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_item   (chain_item[0]),
        .out_cmag   (chain_cmag[0]),
        .out_cneg   (chain_cneg[0])
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_step
        pde_step #(
            .LANES (LANES)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .in_cmag   (chain_cmag[i]),
            .in_cneg   (chain_cneg[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_item  (chain_item[i+1]),
            .out_cmag  (chain_cmag[i+1]),
            .out_cneg  (chain_cneg[i+1])
        );
    end

    pde_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[LANES]),
        .in_ready     (chain_ready[LANES]),
        .in_item      (chain_item[LANES]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_value    (m_tdata),
        .out_overflow (m_tuser)
    );

endmodule

/* hdl/pde_checker.sv */
`include "polynomial_derivative_evaluator_macros.svh"

module pde_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pde_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tuser
);
    import pde_pkg::*;

    logic                out_stall;
    logic                out_sat;
    logic [DATA_W:0]     out_bus;

    assign out_stall = m_tvalid && !m_tready;
    assign out_sat   = (m_tdata == Q_MAX32) || (m_tdata == Q_MIN32);
    assign out_bus   = {m_tdata, m_tuser};

    // A result that was not taken stays on the bus unchanged.
    `PDE_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_bus), "held result changed")

    // An overflow flag always comes with a saturated value.
    `PDE_ASSERT_NOW(a_ovf_sat, m_tvalid && m_tuser, out_sat, "overflow without saturated value")

    // Input backpressure only appears when the whole pipeline is blocked by the output.
    `PDE_ASSERT_NOW(a_full_only, !s_tready, out_stall, "input stalled while output is free")

endmodule

bind polynomial_derivative_evaluator pde_checker u_pde_checker (.*);
